/* rtl/indexed_list_engine_unit_macros.svh */
// Assertion macros shared by the list engine RTL.
`ifndef INDEXED_LIST_ENGINE_UNIT_MACROS_SVH
`define INDEXED_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside of reset.
`define ILE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("list engine check failed");

// Next-cycle implication, checked on the rising edge outside of reset.
`define ILE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("list engine check failed");

`endif

/* rtl/ile_pkg.sv */
// Shared request codes, defaults and cell command type for the list engine.
package ile_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned WordWidthDef  = 32;

  // request kinds
  localparam logic [2:0] REQ_GET    = 3'd0;
  localparam logic [2:0] REQ_APPEND = 3'd1;
  localparam logic [2:0] REQ_INSERT = 3'd2;
  localparam logic [2:0] REQ_POP    = 3'd3;
  localparam logic [2:0] REQ_REMOVE = 3'd4;
  localparam logic [2:0] REQ_SWAP   = 3'd5;

  // broadcast to every cell of the row for one update cycle
  typedef struct packed {
    logic ins;   // write at position, shift higher entries up
    logic rem;   // shift entries at and above position down
    logic swp;   // exchange the two swap positions
  } cell_cmd_t;

endpackage

/* rtl/ile_cell.sv */
// One storage cell of the list row: holds one word and talks to its neighbors.
module ile_cell #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned WORD_WIDTH  = 32,
  parameter int unsigned IDX         = 0,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1),
  localparam int unsigned OW = $clog2(MAX_ENTRIES)
) (
  input  logic                   clk_i,
  input  ile_pkg::cell_cmd_t     cmd_i,
  input  logic [CW-1:0]          upd_pos_i,
  input  logic [OW-1:0]          upd_other_i,
  input  logic [WORD_WIDTH-1:0]  word_i,
  input  logic [WORD_WIDTH-1:0]  swap_a_i,
  input  logic [WORD_WIDTH-1:0]  swap_b_i,
  input  logic [WORD_WIDTH-1:0]  left_i,
  input  logic [WORD_WIDTH-1:0]  right_i,
  input  logic [CW-1:0]          pick_a_idx_i,
  input  logic [OW-1:0]          pick_b_idx_i,
  output logic [WORD_WIDTH-1:0]  data_o,
  output logic [WORD_WIDTH-1:0]  pick_a_o,
  output logic [WORD_WIDTH-1:0]  pick_b_o
);

  logic [WORD_WIDTH-1:0] data_q, data_d;
  logic                  eq_pos, gt_pos, eq_other;

  assign eq_pos   = (upd_pos_i == CW'(IDX));
  assign gt_pos   = (upd_pos_i < CW'(IDX));
  assign eq_other = (upd_other_i == OW'(IDX));

  // pick the next word from the broadcast command and the neighbors
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins && eq_pos) begin
      data_d = word_i;
    end else if (cmd_i.ins && gt_pos) begin
      data_d = left_i;
    end else if (cmd_i.rem && (eq_pos || gt_pos)) begin
      data_d = right_i;
    end else if (cmd_i.swp && eq_pos) begin
      data_d = swap_b_i;
    end else if (cmd_i.swp && eq_other) begin
      data_d = swap_a_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // drive this word onto the read buses only when addressed
  assign data_o   = data_q;
  assign pick_a_o = (pick_a_idx_i == CW'(IDX)) ? data_q : '0;
  assign pick_b_o = (pick_b_idx_i == OW'(IDX)) ? data_q : '0;

endmodule

/* rtl/indexed_list_engine_unit.sv */
// Top level of the list engine: request checks, read buses, cell row, result register.
//
//   channel  | handshake              | fields
//   ---------+------------------------+-----------------------------------------------
//   request  | in_valid_i/in_stall_o   | req_type_i position_i other_position_i data_word_i
//   result   | out_valid_o/out_stall_i | ok_o result_word_o length_now_o
//
// Each word is handled in an accept cycle and an update cycle. The accept cycle checks the
// request and reads the addressed entries through the AND-OR read buses of the cell row into
// registers; the update cycle updates every cell in parallel and loads the result register.
// A new request is taken while a finished result still waits in the result register.
// A stalled result holds the update cycle; the request side then stalls too.
// Reset clears the length and the handshake state; cell contents stay undefined.
module indexed_list_engine_unit #(
  parameter int unsigned MAX_ENTRIES = ile_pkg::MaxEntriesDef,
  parameter int unsigned WORD_WIDTH  = ile_pkg::WordWidthDef,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1),
  localparam int unsigned OW = $clog2(MAX_ENTRIES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            req_type_i,
  input  logic [CW-1:0]         position_i,
  input  logic [OW-1:0]         other_position_i,
  input  logic [WORD_WIDTH-1:0] data_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  ok_o,
  output logic [WORD_WIDTH-1:0] result_word_o,
  output logic [CW-1:0]         length_now_o
);
  import ile_pkg::*;

  `include "indexed_list_engine_unit_macros.svh"

  // handshake and control
  logic busy_q, out_valid_q, in_acc, exec_fire;
  logic [CW-1:0] cnt_q, cnt_d;

  // captured request
  logic                  ok_q, ok_d;
  cell_cmd_t             cmd_q, cmd_d, cell_cmd;
  logic                  res_rd_q, res_rd_d, res_wd_q, res_wd_d;
  logic                  inc_q, inc_d, dec_q, dec_d;
  logic [CW-1:0]         pos_q, pos_d;
  logic [OW-1:0]         oth_q;
  logic [WORD_WIDTH-1:0] word_q, rda_q, rdb_q;

  // result register
  logic                  out_ok_q;
  logic [WORD_WIDTH-1:0] out_word_q, out_word_d;
  logic [CW-1:0]         out_len_q;

  // read buses
  logic [CW-1:0]         pick_a_idx;
  logic [WORD_WIDTH-1:0] bus_a, bus_b;
  logic [WORD_WIDTH-1:0] row_data [MAX_ENTRIES];
  logic [WORD_WIDTH-1:0] pick_a   [MAX_ENTRIES];
  logic [WORD_WIDTH-1:0] pick_b   [MAX_ENTRIES];

  logic          full, pos_in, oth_in;
  logic [CW-1:0] oth_ext;

  assign in_acc    = in_valid_i && !busy_q;
  assign exec_fire = busy_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q;

  assign full    = (cnt_q == CW'(MAX_ENTRIES));
  assign oth_ext = CW'(other_position_i);
  assign pos_in  = (position_i < cnt_q);
  assign oth_in  = (oth_ext < cnt_q);

  // check the request and decode what the row must do
  always_comb begin
    ok_d       = 1'b0;
    cmd_d      = '0;
    res_rd_d   = 1'b0;
    res_wd_d   = 1'b0;
    inc_d      = 1'b0;
    dec_d      = 1'b0;
    pos_d      = position_i;
    pick_a_idx = position_i;
    case (req_type_i)
      REQ_GET: begin
        ok_d     = pos_in;
        res_rd_d = 1'b1;
      end
      REQ_APPEND: begin
        ok_d      = !full;
        cmd_d.ins = 1'b1;
        res_wd_d  = 1'b1;
        inc_d     = 1'b1;
        pos_d     = cnt_q;
      end
      REQ_INSERT: begin
        ok_d      = !full && (position_i <= cnt_q);
        cmd_d.ins = 1'b1;
        res_wd_d  = 1'b1;
        inc_d     = 1'b1;
      end
      REQ_POP: begin
        ok_d       = (cnt_q != '0);
        res_rd_d   = 1'b1;
        dec_d      = 1'b1;
        pick_a_idx = cnt_q - CW'(1);
      end
      REQ_REMOVE: begin
        ok_d      = pos_in;
        cmd_d.rem = 1'b1;
        res_rd_d  = 1'b1;
        dec_d     = 1'b1;
      end
      REQ_SWAP: begin
        ok_d      = pos_in && oth_in && (oth_ext != position_i);
        cmd_d.swp = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // merge the per-cell read outputs
  always_comb begin
    bus_a = '0;
    bus_b = '0;
    for (int unsigned k = 0; k < MAX_ENTRIES; k++) begin
      bus_a = bus_a | pick_a[k];
      bus_b = bus_b | pick_b[k];
    end
  end

  // capture the request and the words it reads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ok_q     <= ok_d;
      cmd_q    <= cmd_d;
      res_rd_q <= res_rd_d;
      res_wd_q <= res_wd_d;
      inc_q    <= inc_d;
      dec_q    <= dec_d;
      pos_q    <= pos_d;
      oth_q    <= other_position_i;
      word_q   <= data_word_i;
      rda_q    <= bus_a;
      rdb_q    <= bus_b;
    end
  end

  // command reaches the cells only in the update cycle of an accepted request
  assign cell_cmd = (exec_fire && ok_q) ? cmd_q : '0;

  // row of storage cells
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = word_q;
    end else begin : g_mid_l
      assign left_w = row_data[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_w = row_data[g];
    end else begin : g_mid_r
      assign right_w = row_data[g+1];
    end
    ile_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .WORD_WIDTH  (WORD_WIDTH),
      .IDX         (g)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cell_cmd),
      .upd_pos_i    (pos_q),
      .upd_other_i  (oth_q),
      .word_i       (word_q),
      .swap_a_i     (rda_q),
      .swap_b_i     (rdb_q),
      .left_i       (left_w),
      .right_i      (right_w),
      .pick_a_idx_i (pick_a_idx),
      .pick_b_idx_i (other_position_i),
      .data_o       (row_data[g]),
      .pick_a_o     (pick_a[g]),
      .pick_b_o     (pick_b[g])
    );
  end

  // next length and result word
  always_comb begin
    cnt_d = cnt_q;
    if (ok_q && inc_q) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ok_q && dec_q) begin
      cnt_d = cnt_q - CW'(1);
    end
    out_word_d = '0;
    if (ok_q && res_rd_q) begin
      out_word_d = rda_q;
    end else if (ok_q && res_wd_q) begin
      out_word_d = word_q;
    end
  end

  // advance the handshake state and the length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (exec_fire) begin
        busy_q <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // load the result register
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_ok_q   <= ok_q;
      out_word_q <= out_word_d;
      out_len_q  <= cnt_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign result_word_o = out_word_q;
  assign length_now_o  = out_len_q;

  `ILE_ASSERT_NOW(a_len_bound, 1'b1, cnt_q <= CW'(MAX_ENTRIES))
  `ILE_ASSERT_NEXT(a_acc_busy, in_acc, busy_q)
  `ILE_ASSERT_NEXT(a_exec_result, exec_fire, out_valid_q && !busy_q)
  `ILE_ASSERT_NEXT(a_len_hold, !exec_fire, $stable(cnt_q))
  `ILE_ASSERT_NOW(a_reject_zero, out_valid_q && !out_ok_q, out_word_q == '0)

endmodule

/* tb/tb_indexed_list_engine_unit.sv */
// Self-checking testbench for the indexed list engine: request driver, result monitor, list model.
`timescale 1ns / 100ps

// One expected result word
typedef struct packed {
  logic        ok;
  logic [31:0] word;
  logic [4:0]  len;
} list_reply_t;

// Shadow list: tracks entries and length, queues the reply each request should produce
class list_scoreboard;
  bit [ile_pkg::WordWidthDef-1:0] entries[ile_pkg::MaxEntriesDef];
  int unsigned                    count;
  list_reply_t                    replies[$];
  int                             errors;

  // Apply one accepted request to the shadow list and queue its reply
  function void note_request(logic [2:0] kind, logic [4:0] pos, logic [3:0] oth,
                             logic [31:0] word);
    list_reply_t                    r;
    bit [ile_pkg::WordWidthDef-1:0] held;
    int                             i;
    r.ok   = 1'b0;
    r.word = '0;
    case (kind)
      ile_pkg::REQ_GET: begin
        if (pos < count) begin
          r.ok   = 1'b1;
          r.word = entries[pos];
        end
      end
      ile_pkg::REQ_APPEND: begin
        if (count < ile_pkg::MaxEntriesDef) begin
          entries[count] = word;
          count++;
          r.ok   = 1'b1;
          r.word = word;
        end
      end
      ile_pkg::REQ_INSERT: begin
        if (pos <= count && count < ile_pkg::MaxEntriesDef) begin
          for (i = count; i > pos; i--) entries[i] = entries[i-1];
          entries[pos] = word;
          count++;
          r.ok   = 1'b1;
          r.word = word;
        end
      end
      ile_pkg::REQ_POP: begin
        if (count > 0) begin
          count--;
          r.ok   = 1'b1;
          r.word = entries[count];
        end
      end
      ile_pkg::REQ_REMOVE: begin
        if (pos < count) begin
          held = entries[pos];
          for (i = pos; i + 1 < count; i++) entries[i] = entries[i+1];
          count--;
          r.ok   = 1'b1;
          r.word = held;
        end
      end
      ile_pkg::REQ_SWAP: begin
        if (pos < count && oth < count && pos != oth) begin
          held         = entries[pos];
          entries[pos] = entries[oth];
          entries[oth] = held;
          r.ok         = 1'b1;
        end
      end
      default: ;
    endcase
    r.len = count[4:0];
    replies.push_back(r);
  endfunction

  // Compare one accepted result word with the oldest queued reply
  function void check_result(logic ok, logic [31:0] word, logic [4:0] len);
    list_reply_t e;
    if (replies.size() == 0) begin
      $display("%0t: result with nothing pending: ok %0d word %h len %0d",
               $time, ok, word, len);
      errors++;
      return;
    end
    e = replies.pop_front();
    if (ok !== e.ok) begin
      $display("%0t: ok mismatch: expected %0d actual %0d", $time, e.ok, ok);
      errors++;
    end
    if (word !== e.word) begin
      $display("%0t: result_word mismatch: expected %h actual %h", $time, e.word, word);
      errors++;
    end
    if (len !== e.len) begin
      $display("%0t: length_now mismatch: expected %0d actual %0d", $time, e.len, len);
      errors++;
    end
  endfunction

  function int pending();
    return replies.size();
  endfunction
endclass

module tb_indexed_list_engine_unit;
  import ile_pkg::*;

  localparam logic [2:0] REQ_BAD_LO = 3'd6;
  localparam logic [2:0] REQ_BAD_HI = 3'd7;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 850;
  localparam int unsigned Phases      = 9;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  req_type_i;
  logic [4:0]  position_i;
  logic [3:0]  other_position_i;
  logic [31:0] data_word_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        ok_o;
  logic [31:0] result_word_o;
  logic [4:0]  length_now_o;

  list_scoreboard sb;
  bit             sender_idle;
  bit             receiver_idle;
  int unsigned    stall_left = 0;
  int unsigned    cycles = 0;

  indexed_list_engine_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .position_i       (position_i),
    .other_position_i (other_position_i),
    .data_word_i      (data_word_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ok_o             (ok_o),
    .result_word_o    (result_word_o),
    .length_now_o     (length_now_o)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Take result words, then hold off for a random number of cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(ok_o, result_word_o, length_now_o);
        stall_left = receiver_idle ? $urandom_range(0, 17) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  // Drive one request word after a random gap and hold it until accepted
  task automatic send_request(logic [2:0] kind, logic [4:0] pos, logic [3:0] oth,
                              logic [31:0] word);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_type_i       <= kind;
    position_i       <= pos;
    other_position_i <= oth;
    data_word_i      <= word;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(kind, pos, oth, word);
  endtask

  // Hold the sender until every queued reply has come back
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [2:0]  kind;
    logic [4:0]  pos;
    logic [3:0]  oth;
    logic [31:0] word;
    bit          draining;
    int unsigned roll;
    int unsigned phase;
    int unsigned n;

    sb               = new();
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    req_type_i       = REQ_GET;
    position_i       = '0;
    other_position_i = '0;
    data_word_i      = '0;
    sender_idle      = 1'b1;
    receiver_idle    = 1'b1;
    draining         = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: every read-type request and an insert past the end are rejected
    send_request(REQ_GET,    5'd0, 4'd0, 32'h1234_5678);
    send_request(REQ_POP,    5'd0, 4'd0, 32'h0);
    send_request(REQ_REMOVE, 5'd0, 4'd0, 32'h0);
    send_request(REQ_SWAP,   5'd0, 4'd1, 32'h0);
    send_request(REQ_INSERT, 5'd1, 4'd0, 32'hDEAD_BEEF);
    // Unknown request kinds
    send_request(REQ_BAD_LO, 5'd0, 4'd0, 32'hFFFF_FFFF);
    send_request(REQ_BAD_HI, 5'd16, 4'd15, 32'hFFFF_FFFF);
    // Data extremes, insert at front and at the end
    send_request(REQ_APPEND, 5'd0, 4'd0, 32'h0000_0000);
    send_request(REQ_APPEND, 5'd0, 4'd0, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 5'd0, 4'd0, 32'hA5A5_A5A5);
    send_request(REQ_INSERT, 5'd3, 4'd0, 32'h5A5A_5A5A);
    // Fill to capacity
    while (sb.count < MaxEntriesDef) begin
      if (sb.count % 2 == 0) send_request(REQ_APPEND, 5'd0, 4'd0, $urandom());
      else send_request(REQ_INSERT, 5'($urandom_range(0, sb.count)), 4'd0, $urandom());
    end
    // Full list and top-end positions
    send_request(REQ_APPEND, 5'd0,  4'd0,  32'h0BAD_0BAD);
    send_request(REQ_INSERT, 5'd16, 4'd0,  32'h0BAD_0BAD);
    send_request(REQ_GET,    5'd16, 4'd0,  32'h0);
    send_request(REQ_SWAP,   5'd0,  4'd15, 32'h0);
    send_request(REQ_SWAP,   5'd7,  4'd7,  32'h0);
    send_request(REQ_GET,    5'd15, 4'd0,  32'h0);
    send_request(REQ_REMOVE, 5'd0,  4'd0,  32'h0);
    drain_replies();

    // Random traffic: fill and drain sweeps with random content
    for (phase = 0; phase < Phases; phase++) begin
      sender_idle   = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      for (n = 0; n < RandomItems / Phases; n++) begin
        if (sb.count == MaxEntriesDef) draining = 1'b1;
        else if (sb.count == 0) draining = 1'b0;
        else if ($urandom_range(0, 99) < 3) draining = ~draining;

        roll = $urandom_range(0, 99);
        if (roll < 4) kind = $urandom_range(0, 1) ? REQ_BAD_LO : REQ_BAD_HI;
        else if (roll < 19) kind = REQ_GET;
        else if (!draining) begin
          if (roll < 49)      kind = REQ_APPEND;
          else if (roll < 74) kind = REQ_INSERT;
          else if (roll < 84) kind = REQ_SWAP;
          else if (roll < 92) kind = REQ_POP;
          else                kind = REQ_REMOVE;
        end else begin
          if (roll < 44)      kind = REQ_POP;
          else if (roll < 69) kind = REQ_REMOVE;
          else if (roll < 84) kind = REQ_SWAP;
          else if (roll < 92) kind = REQ_APPEND;
          else                kind = REQ_INSERT;
        end

        // Mostly in-range positions, some anywhere from 0 to 16
        if ($urandom_range(0, 99) < 15) pos = 5'($urandom_range(0, 16));
        else if (kind == REQ_INSERT) pos = 5'($urandom_range(0, sb.count));
        else pos = (sb.count > 0) ? 5'($urandom_range(0, sb.count - 1)) : 5'd0;

        if (kind == REQ_SWAP && sb.count > 0 && $urandom_range(0, 99) < 85)
          oth = 4'($urandom_range(0, sb.count - 1));
        else
          oth = 4'($urandom_range(0, 15));

        roll = $urandom_range(0, 9);
        if (roll == 0)      word = 32'h0000_0000;
        else if (roll == 1) word = 32'hFFFF_FFFF;
        else                word = $urandom();

        send_request(kind, pos, oth, word);
      end
      if (phase == Phases / 2) drain_replies();
    end

    drain_replies();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
